// ----- hw/rtl/ira_pkg.sv -----
// Shared types, constants and helper functions for the integer to radix ASCII converter.
package ira_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int RADIX_BITS         = 6;
    localparam int CHAR_BITS          = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_BITS-1:0] DIGIT_MAX_DEC = 6'd9;

    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_Z     = 8'h7a;
    localparam logic [CHAR_BITS-1:0] DIGIT_TEN  = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } ira_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic push;
        logic rd;
        logic emit_sign;
        logic emit_digit;
    } ira_cmd_t;

    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic negative;
        logic count_zero;
        logic out_free;
    } ira_status_t;

    function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
        logic [RADIX_BITS-1:0] res;
        res = r;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        return res;
    endfunction

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] d_ext;
        logic [CHAR_BITS-1:0] res;
        d_ext = {{(CHAR_BITS-RADIX_BITS){1'b0}}, d};
        if (d > DIGIT_MAX_DEC)
            res = CHAR_A + d_ext - DIGIT_TEN;
        else
            res = CHAR_ZERO + d_ext;
        return res;
    endfunction

endpackage

// ----- hw/rtl/integer_to_radix_ascii_unit.sv -----
// Top level: signed integer to ASCII text in radix 2 to 36, most significant character first.
// Each digit comes from bit-serial restoring division of the magnitude and is then stacked.
// Characters then leave one at a time when the sink is ready; a '-' leads negatives.
// A new beat is taken once the last character sits in the output register.
// Reset is asynchronous and active low; it clears the state, counters and output valid flag.
// The digit RAM needs no clearing because every digit is written before it is read.
module integer_to_radix_ascii_unit #(
    parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    s_tvalid,
    output logic                                                    s_tready,
    // s_tdata, from bit 0 up: value, radix, zero padding to whole bytes.
    input  logic [((VALUE_BITS + ira_pkg::RADIX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                                    m_tvalid,
    input  logic                                                    m_tready,
    // m_tdata, from bit 0 up: character.
    output logic [ira_pkg::CHAR_BITS-1:0]                           m_tdata,
    output logic                                                    m_tlast
);

    ira_pkg::ira_cmd_t    cmd;
    ira_pkg::ira_status_t status;

    ira_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ira_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .radix     (s_tdata[VALUE_BITS +: ira_pkg::RADIX_BITS]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .character (m_tdata),
        .last      (m_tlast)
    );

endmodule

// ----- hw/rtl/ira_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ira_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/ira_ctrl.sv -----
// Sequencing state machine: divide, stack digits, then emit sign and digits.
module ira_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  ira_pkg::ira_status_t status,
    output ira_pkg::ira_cmd_t    cmd
);

    ira_pkg::ira_state_t state_reg;
    ira_pkg::ira_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ira_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ira_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ira_pkg::ST_DIV;
                end
            end
            ira_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ira_pkg::ST_PUSH;
            end
            ira_pkg::ST_PUSH:
            begin
                cmd.push = 1'b1;
                // The quotient is already in place; a zero quotient ends the digit loop.
                if (!status.quot_zero)
                    state_next = ira_pkg::ST_DIV;
                else if (status.negative)
                    state_next = ira_pkg::ST_SIGN;
                else
                    state_next = ira_pkg::ST_READ;
            end
            ira_pkg::ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ira_pkg::ST_READ;
                end
            end
            ira_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ira_pkg::ST_EMIT;
            end
            ira_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    state_next     = status.count_zero ? ira_pkg::ST_IDLE : ira_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = ira_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ira_datapath.sv -----
// Datapath: bit-serial restoring divider, digit stack and output register.
module ira_datapath #(
    parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ira_pkg::ira_cmd_t                  cmd,
    output ira_pkg::ira_status_t               status,
    input  logic [VALUE_BITS-1:0]              value,
    input  logic [ira_pkg::RADIX_BITS-1:0]     radix,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ira_pkg::CHAR_BITS-1:0]      character,
    output logic                               last
);

    localparam int RB = ira_pkg::RADIX_BITS;
    localparam int SB = $clog2(VALUE_BITS);
    localparam int CB = $clog2(VALUE_BITS + 1);
    localparam int AB = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0]            quot_reg, quot_next;
    logic [RB-1:0]                    rem_reg, rem_next;
    logic [RB-1:0]                    radix_reg, radix_next;
    logic                             neg_reg, neg_next;
    logic [SB-1:0]                    step_reg, step_next;
    logic [CB-1:0]                    count_reg, count_next;
    logic [ira_pkg::CHAR_BITS-1:0]    out_char_reg, out_char_next;
    logic                             out_last_reg, out_last_next;
    logic                             out_valid_reg, out_valid_next;

    logic [RB:0]     trial;
    logic [RB:0]     diff;
    logic            q_bit;
    logic [CB-1:0]   count_dec;
    logic [RB-1:0]   ram_rd_data;

    // One quotient bit per cycle: shift the next dividend bit into the partial remainder.
    assign trial     = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign diff      = trial - {1'b0, radix_reg};
    assign q_bit     = (trial >= {1'b0, radix_reg});
    assign count_dec = count_reg - CB'(1);

    ira_ram #(
        .WIDTH (RB),
        .DEPTH (VALUE_BITS)
    ) u_digit_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (count_reg[AB-1:0]),
        .wr_data (rem_reg),
        .rd_en   (cmd.rd),
        .rd_addr (count_dec[AB-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            neg_next   = value[VALUE_BITS-1];
            quot_next  = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
            radix_next = ira_pkg::clamp_radix(radix);
            rem_next   = '0;
            step_next  = '0;
            count_next = '0;
        end
        if (cmd.div_step)
        begin
            quot_next = {quot_reg[VALUE_BITS-2:0], q_bit};
            rem_next  = q_bit ? diff[RB-1:0] : trial[RB-1:0];
            step_next = step_reg + SB'(1);
        end
        if (cmd.push)
        begin
            count_next = count_reg + CB'(1);
            rem_next   = '0;
            step_next  = '0;
        end
        if (cmd.rd)
        begin
            count_next = count_dec;
        end

        if (m_tready)
            out_valid_next = 1'b0;
        if (cmd.emit_sign)
        begin
            out_char_next  = ira_pkg::CHAR_MINUS;
            out_last_next  = 1'b0;
            out_valid_next = 1'b1;
        end
        if (cmd.emit_digit)
        begin
            out_char_next  = ira_pkg::digit_char(ram_rd_data);
            out_last_next  = (count_reg == '0);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        radix_reg    <= radix_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign status.div_last   = (step_reg == SB'(VALUE_BITS - 1));
    assign status.quot_zero  = (quot_reg == '0);
    assign status.negative   = neg_reg;
    assign status.count_zero = (count_reg == '0);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign character = out_char_reg;
    assign last      = out_last_reg;

endmodule

// ----- hw/rtl/ira_checker.sv -----
// Port-level checker for the converter, attached to the top level by bind.
module ira_checker #(
    parameter int VALUE_BITS = ira_pkg::VALUE_BITS_DEFAULT
) (
    input logic                                                    clk,
    input logic                                                    rst_n,
    input logic                                                    s_tvalid,
    input logic                                                    s_tready,
    input logic [((VALUE_BITS + ira_pkg::RADIX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input logic                                                    m_tvalid,
    input logic                                                    m_tready,
    input logic [ira_pkg::CHAR_BITS-1:0]                           m_tdata,
    input logic                                                    m_tlast
);

    // A stalled output beat must hold its character and flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // Once a value is taken, the converter is busy dividing on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("converter not busy after accepting a value");

    // Every character is a sign, a decimal digit or a lower-case letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == ira_pkg::CHAR_MINUS)
                  || (m_tdata >= ira_pkg::CHAR_ZERO && m_tdata <= ira_pkg::CHAR_NINE)
                  || (m_tdata >= ira_pkg::CHAR_A && m_tdata <= ira_pkg::CHAR_Z))
        else $error("character outside the digit alphabet");

    // The sign never ends a number.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata != ira_pkg::CHAR_MINUS)
        else $error("sign marked as last character");

endmodule

bind integer_to_radix_ascii_unit ira_checker #(.VALUE_BITS(VALUE_BITS)) u_ira_checker (.*);

// ----- test/integer_to_radix_ascii_unit_tb.sv -----
// Self-checking testbench for the integer to radix ASCII converter: table-driven and random values.
module integer_to_radix_ascii_unit_tb;

    localparam int VALUE_BITS   = ira_pkg::VALUE_BITS_DEFAULT;
    localparam int RADIX_W      = ira_pkg::RADIX_BITS;
    localparam int CHAR_W       = ira_pkg::CHAR_BITS;
    localparam int DATA_W       = ((VALUE_BITS + RADIX_W + 7) / 8) * 8;
    localparam int PAD_W        = DATA_W - VALUE_BITS - RADIX_W;
    localparam int VALUE_TOTAL  = 410;
    localparam int QUIET_VALUES = 40;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 700;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 12000;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } char_beat_t;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]    radix;
        string                 text;
    } text_case_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [CHAR_W-1:0] m_tdata;
    logic              m_tlast;

    char_beat_t expected_chars[$];
    text_case_t text_cases[$];
    int         fail_count  = 0;
    int         chars_seen  = 0;
    int         values_sent = 0;
    int         stall_count = 0;
    logic       quiet;

    assign quiet = (values_sent >= VALUE_TOTAL - QUIET_VALUES);

    integer_to_radix_ascii_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #10 clk = ~clk;

    // Sign first, then the digits of the magnitude, most significant first.
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
        logic [VALUE_BITS-1:0] mag;
        int unsigned           base;
        int unsigned           digit;
        logic [CHAR_W-1:0]     digit_text[$];
        mag  = value[VALUE_BITS-1] ? -value : value;
        base = 32'(radix);
        if (base < 32'(ira_pkg::RADIX_MIN))
            base = 32'(ira_pkg::RADIX_MIN);
        else if (base > 32'(ira_pkg::RADIX_MAX))
            base = 32'(ira_pkg::RADIX_MAX);
        do
        begin
            digit = mag % base;
            mag   = mag / base;
            if (digit > 32'(ira_pkg::DIGIT_MAX_DEC))
                digit_text.push_front(ira_pkg::CHAR_A + CHAR_W'(digit) - ira_pkg::DIGIT_TEN);
            else
                digit_text.push_front(ira_pkg::CHAR_ZERO + CHAR_W'(digit));
        end
        while (mag != 0);
        if (value[VALUE_BITS-1])
            expected_chars.push_back('{ira_pkg::CHAR_MINUS, 1'b0});
        foreach (digit_text[i])
            expected_chars.push_back('{digit_text[i], i == digit_text.size() - 1});
    endfunction

    task automatic add_case(input logic [VALUE_BITS-1:0] value,
                            input logic [RADIX_W-1:0] radix, input string text);
        text_case_t row;
        row.value = value;
        row.radix = radix;
        row.text  = text;
        text_cases.push_back(row);
    endtask

    // Entered and left at a falling edge; an empty text means the predictor supplies it.
    task automatic send_value(input logic [VALUE_BITS-1:0] value,
                              input logic [RADIX_W-1:0] radix, input string text);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, radix, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (text.len() == 0)
            predict_text(value, radix);
        else
            for (int i = 0; i < text.len(); i++)
                expected_chars.push_back('{text[i], i == text.len() - 1});
        values_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]    radix;
        longint                power;
        int unsigned           base;
        int                    steps;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;

        add_case(32'd0,          6'd10, "0");
        add_case(32'd0,          6'd2,  "0");
        add_case(32'd1,          6'd2,  "1");
        add_case(-32'sd1,        6'd10, "-1");
        add_case(-32'sd1,        6'd16, "-1");
        add_case(32'h7fffffff,   6'd10, "2147483647");
        add_case(32'h80000000,   6'd10, "-2147483648");
        add_case(32'h80000000,   6'd2,
                 {"-1", "0000000000", "0000000000", "0000000000", "0"});
        add_case(32'h80000000,   6'd16, "-80000000");
        add_case(32'h7fffffff,   6'd16, "7fffffff");
        add_case(32'h7fffffff,   6'd2,  "");
        add_case(32'h80000000,   6'd36, "");
        add_case(32'h7fffffff,   6'd36, "");
        add_case(32'd9,          6'd10, "9");
        add_case(32'd10,         6'd11, "a");
        add_case(32'd35,         6'd36, "z");
        add_case(-32'sd35,       6'd36, "-z");
        add_case(32'd255,        6'd16, "ff");
        add_case(32'd12345,      6'd10, "12345");
        add_case(-32'sd12345678, 6'd8,  "");
        // Radix values outside two to thirty-six are pulled into that range.
        add_case(32'd5,          6'd0,  "101");
        add_case(32'd5,          6'd1,  "101");
        add_case(32'd36,         6'd37, "10");
        add_case(32'd35,         6'd63, "z");
        add_case(-32'sd100,      6'd63, "");

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (text_cases[i])
            send_value(text_cases[i].value, text_cases[i].radix, text_cases[i].text);

        while (values_sent < VALUE_TOTAL)
        begin
            case ($urandom_range(0, 19))
                0:       radix = RADIX_W'($urandom_range(0, 63));
                1:       radix = ira_pkg::RADIX_MIN;
                default: radix = RADIX_W'($urandom_range(2, 36));
            endcase
            case ($urandom_range(0, 9))
                0:
                begin
                    case ($urandom_range(0, 4))
                        0:       value = '0;
                        1:       value = '1;
                        2:       value = 32'd1;
                        3:       value = 32'h80000000;
                        default: value = 32'h7fffffff;
                    endcase
                end
                1, 2:
                begin
                    value = VALUE_BITS'($urandom_range(0, 1000));
                    if ($urandom_range(0, 1))
                        value = -value;
                end
                8, 9:
                begin
                    // Around a power of the radix, where the digit count changes.
                    base = 32'(radix);
                    if (base < 32'(ira_pkg::RADIX_MIN))
                        base = 32'(ira_pkg::RADIX_MIN);
                    else if (base > 32'(ira_pkg::RADIX_MAX))
                        base = 32'(ira_pkg::RADIX_MAX);
                    power = 1;
                    steps = $urandom_range(1, 31);
                    repeat (steps)
                        if (power * base <= 64'h7fffffff)
                            power = power * base;
                    value = VALUE_BITS'(power - $urandom_range(0, 1));
                    if ($urandom_range(0, 1))
                        value = -value;
                end
                default: value = VALUE_BITS'($urandom());
            endcase
            send_value(value, radix, "");
        end
        s_tvalid <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Sink side: short random stalls, and one long hold that backs the block up.
    initial
    begin
        int  hold_left;
        bit  long_hold_done;
        hold_left      = 0;
        long_hold_done = 0;
        m_tready       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!long_hold_done && chars_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1;
                hold_left      = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && rst_n && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                $error("character: expected none, got 0x%02h (last %0b)", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.character)
                begin
                    $error("character: expected 0x%02h, got 0x%02h", want.character, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Counts cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_count = 0;
        else
        begin
            stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
